/* sv/i2c_master_byte_sequencer_core_defines.svh */
// Assertion macros used by the sequencer checker.
// No dependencies; included by the checker file.
`ifndef I2C_MASTER_BYTE_SEQUENCER_CORE_DEFINES_SVH
`define I2C_MASTER_BYTE_SEQUENCER_CORE_DEFINES_SVH

// Property checked only while out of reset.
`define I2CS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included.
`define I2CS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/i2cs_pkg.sv */
// Types and constants of the I2C master byte sequencer.
// No dependencies; imported by the top level, the front end and the sequencer.
package i2cs_pkg;

    typedef enum logic [2:0] {
        OP_INIT    = 3'd0,
        OP_START   = 3'd1,
        OP_STOP    = 3'd2,
        OP_WRITE   = 3'd3,
        OP_READ    = 3'd4,
        OP_ADDR_WR = 3'd5,
        OP_ADDR_RD = 3'd6
    } t_op;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_INIT,
        SQ_START,
        SQ_STOP,
        SQ_WBIT,
        SQ_WACK,
        SQ_RBIT,
        SQ_RACK
    } t_seq_state;

    // Decoded command as it travels from front to back.
    typedef struct packed {
        t_op        op;
        logic [7:0] wbyte;
        logic       send_ack;
        logic [7:0] rd_data;
        logic       ack;
    } t_cmd;

    // One pin segment.
    typedef struct packed {
        logic       scl;
        logic       sda;
        logic [7:0] rd_data;
        logic       ack;
        logic       last;
    } t_seg;

    localparam logic [15:0] SEG_CYCLES_RST = 16'd250;

endpackage

/* sv/i2c_master_byte_sequencer_core.sv */
// I2C master byte sequencer. Each command expands into timed pin segments
// (init 1, start 3, stop 2, write 26, read 20, address write/read 29), one
// result per segment; the last carries the byte read and the sampled ack.
// Segments are paced by a down-counter in the sequencer that reloads from
// the segment_cycles register (reset SEG_CYCLES_RST), and are held while
// the result queue is full. Commands are decoded and queued while the
// sequencer works; the next one is popped in the cycle its predecessor's
// last segment is issued. Code 7 is accepted and dropped.
module i2c_master_byte_sequencer_core #(
    parameter int CMD_DEPTH = 2,
    parameter int RES_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  i_operation,
    input  logic [7:0]  i_data_byte,
    input  logic        i_send_ack,
    input  logic [8:0]  i_target_sda,
    output logic        empty,
    input  logic        pop,
    output logic        o_scl_level,
    output logic        o_sda_level,
    output logic [7:0]  o_read_data,
    output logic        o_ack_sampled,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);
    import i2cs_pkg::*;

    localparam int CMD_W = $bits(t_cmd);
    localparam int SEG_W = $bits(t_seg);

    t_cmd             front_cmd;
    logic             front_wr;
    logic             cmd_full, cmd_empty, cmd_pop;
    logic [CMD_W-1:0] cmd_bits;
    t_cmd             head_cmd;
    logic             res_full, emit;
    t_seg             seg, res_seg;
    logic [SEG_W-1:0] res_bits;

    assign o_cfg_ready = 1'b1;

    i2cs_front u_front (
        .i_push       (push),
        .i_operation  (i_operation),
        .i_data_byte  (i_data_byte),
        .i_send_ack   (i_send_ack),
        .i_target_sda (i_target_sda),
        .i_q_full     (cmd_full),
        .o_full       (full),
        .o_q_wr       (front_wr),
        .o_cmd        (front_cmd)
    );

    i2cs_queue #(.DATA_W(CMD_W), .DEPTH(CMD_DEPTH)) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (front_wr),
        .i_data  (front_cmd),
        .i_rd    (cmd_pop),
        .o_data  (cmd_bits),
        .o_full  (cmd_full),
        .o_empty (cmd_empty)
    );

    assign head_cmd = t_cmd'(cmd_bits);

    i2cs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr    (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (head_cmd),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_emit      (emit),
        .o_seg       (seg)
    );

    i2cs_queue #(.DATA_W(SEG_W), .DEPTH(RES_DEPTH)) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (emit),
        .i_data  (seg),
        .i_rd    (pop),
        .o_data  (res_bits),
        .o_full  (res_full),
        .o_empty (empty)
    );

    assign res_seg       = t_seg'(res_bits);
    assign o_scl_level   = res_seg.scl;
    assign o_sda_level   = res_seg.sda;
    assign o_read_data   = res_seg.rd_data;
    assign o_ack_sampled = res_seg.ack;
    assign o_last        = res_seg.last;

endmodule

/* sv/i2cs_queue.sv */
// Small synchronous FIFO used for the command and result queues.
// Depends on nothing; data is a flat vector.
module i2cs_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr,
    input  logic [DATA_W-1:0] i_data,
    input  logic              i_rd,
    output logic [DATA_W-1:0] o_data,
    output logic              o_full,
    output logic              o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wptr, n_wptr;
    logic [PTR_W-1:0]  r_rptr, n_rptr;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              wr_en, rd_en;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_data  = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (wr_en) begin
            n_wptr = (r_wptr == PTR_LAST) ? '0 : r_wptr + 1'b1;
        end
        if (rd_en) begin
            n_rptr = (r_rptr == PTR_LAST) ? '0 : r_rptr + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

/* sv/i2cs_front.sv */
// Command front end: accepts commands and decodes them for the sequencer.
// Depends on i2cs_pkg.
module i2cs_front (
    input  logic          i_push,
    input  logic [2:0]    i_operation,
    input  logic [7:0]    i_data_byte,
    input  logic          i_send_ack,
    input  logic [8:0]    i_target_sda,
    input  logic          i_q_full,
    output logic          o_full,
    output logic          o_q_wr,
    output i2cs_pkg::t_cmd o_cmd
);
    import i2cs_pkg::*;

    t_op  op;
    logic op_known;

    assign op       = t_op'(i_operation);
    assign op_known = (i_operation <= OP_ADDR_RD);
    assign o_full   = i_q_full;
    // unknown codes are taken and dropped
    assign o_q_wr   = i_push && !i_q_full && op_known;

    always_comb begin
        o_cmd          = '0;
        o_cmd.op       = op;
        o_cmd.send_ack = i_send_ack;
        case (op)
            OP_WRITE: begin
                o_cmd.wbyte = i_data_byte;
                o_cmd.ack   = i_target_sda[0];
            end
            OP_ADDR_WR: begin
                o_cmd.wbyte = {i_data_byte[6:0], 1'b0};
                o_cmd.ack   = i_target_sda[0];
            end
            OP_ADDR_RD: begin
                o_cmd.wbyte = {i_data_byte[6:0], 1'b1};
                o_cmd.ack   = i_target_sda[0];
            end
            OP_READ: begin
                o_cmd.rd_data = i_target_sda[8:1];
            end
            default: begin
                o_cmd.wbyte = '0;
            end
        endcase
    end

endmodule

/* sv/i2cs_back.sv */
// Segment sequencer: walks each command through its pin segments and
// paces them by the segment timer. Depends on i2cs_pkg.
module i2cs_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_wr,
    input  logic [15:0]    i_cfg_data,
    input  i2cs_pkg::t_cmd i_cmd,
    input  logic           i_cmd_empty,
    output logic           o_cmd_pop,
    input  logic           i_res_full,
    output logic           o_emit,
    output i2cs_pkg::t_seg o_seg
);
    import i2cs_pkg::*;

    t_seq_state  r_state, n_state;
    logic [1:0]  r_phase, n_phase;
    logic [2:0]  r_bit, n_bit;
    logic [7:0]  r_shift, n_shift;
    t_cmd        r_cmd, n_cmd;
    logic        r_sda_held, n_sda_held;
    logic [15:0] r_timer, n_timer;
    logic [15:0] r_seg_cycles;
    logic        load;

    function automatic t_seq_state first_state(input t_op op);
        case (op)
            OP_INIT:    first_state = SQ_INIT;
            OP_START:   first_state = SQ_START;
            OP_STOP:    first_state = SQ_STOP;
            OP_WRITE:   first_state = SQ_WBIT;
            OP_READ:    first_state = SQ_RBIT;
            OP_ADDR_WR: first_state = SQ_START;
            OP_ADDR_RD: first_state = SQ_START;
            default:    first_state = SQ_IDLE;
        endcase
    endfunction

    assign o_emit = (r_state != SQ_IDLE) && (r_timer == '0) && !i_res_full;
    // next command is picked up when idle or on the last segment
    assign load      = !i_cmd_empty && ((r_state == SQ_IDLE) || (o_emit && o_seg.last));
    assign o_cmd_pop = load;

    // segment levels
    always_comb begin
        o_seg      = '0;
        o_seg.scl  = 1'b1;
        o_seg.sda  = 1'b1;
        case (r_state)
            SQ_INIT: begin
                o_seg.last = 1'b1;
            end
            SQ_START: begin
                o_seg.scl  = (r_phase == 2'd2) ? 1'b0 : 1'b1;
                o_seg.sda  = (r_phase == 2'd0);
                o_seg.last = (r_phase == 2'd2) && (r_cmd.op == OP_START);
            end
            SQ_STOP: begin
                o_seg.sda  = (r_phase == 2'd0) ? r_sda_held : 1'b1;
                o_seg.last = (r_phase == 2'd1);
            end
            SQ_WBIT: begin
                o_seg.scl = (r_phase == 2'd0);
                o_seg.sda = (r_phase == 2'd2) ? 1'b0 : r_shift[7];
            end
            SQ_WACK: begin
                o_seg.scl  = (r_phase == 2'd0);
                o_seg.last = (r_phase == 2'd1);
            end
            SQ_RBIT: begin
                o_seg.scl = (r_phase == 2'd0);
            end
            SQ_RACK: begin
                o_seg.scl  = (r_phase == 2'd0);
                o_seg.sda  = (r_phase[1]) ? 1'b0 : !r_cmd.send_ack;
                o_seg.last = (r_phase == 2'd3);
            end
            default: begin
                o_seg.last = 1'b0;
            end
        endcase
        if (o_seg.last) begin
            o_seg.rd_data = r_cmd.rd_data;
            o_seg.ack     = r_cmd.ack;
        end
    end

    // next state
    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_bit      = r_bit;
        n_shift    = r_shift;
        n_cmd      = r_cmd;
        n_sda_held = r_sda_held;
        n_timer    = r_timer;
        if (o_emit) begin
            n_sda_held = o_seg.sda;
            n_timer    = r_seg_cycles - 16'd1;
        end else if (r_timer != '0) begin
            n_timer = r_timer - 16'd1;
        end
        if (load) begin
            n_state = first_state(i_cmd.op);
            n_cmd   = i_cmd;
            n_shift = i_cmd.wbyte;
            n_phase = '0;
            n_bit   = '0;
        end else if (o_emit) begin
            if (o_seg.last) begin
                n_state = SQ_IDLE;
            end else begin
                n_phase = r_phase + 2'd1;
                case (r_state)
                    SQ_START: begin
                        if (r_phase == 2'd2) begin
                            n_state = SQ_WBIT;
                            n_phase = '0;
                        end
                    end
                    SQ_WBIT: begin
                        if (r_phase == 2'd2) begin
                            n_shift = {r_shift[6:0], 1'b0};
                            n_phase = '0;
                            n_bit   = r_bit + 3'd1;
                            if (r_bit == 3'd7) begin
                                n_state = SQ_WACK;
                            end
                        end
                    end
                    SQ_RBIT: begin
                        if (r_phase == 2'd1) begin
                            n_phase = '0;
                            n_bit   = r_bit + 3'd1;
                            if (r_bit == 3'd7) begin
                                n_state = SQ_RACK;
                            end
                        end
                    end
                    default: begin
                        n_state = r_state;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= SQ_IDLE;
            r_phase      <= '0;
            r_bit        <= '0;
            r_sda_held   <= 1'b1;
            r_timer      <= '0;
            r_seg_cycles <= SEG_CYCLES_RST;
        end else begin
            r_state    <= n_state;
            r_phase    <= n_phase;
            r_bit      <= n_bit;
            r_sda_held <= n_sda_held;
            r_timer    <= n_timer;
            if (i_cfg_wr) begin
                r_seg_cycles <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
        r_cmd   <= n_cmd;
    end

endmodule

/* sv/i2cs_checker.sv */
// Port-level checks for the sequencer, bound to the top level.
// Depends on i2c_master_byte_sequencer_core_defines.svh.
`include "i2c_master_byte_sequencer_core_defines.svh"

module i2cs_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       empty,
    input logic       pop,
    input logic       o_scl_level,
    input logic       o_sda_level,
    input logic [7:0] o_read_data,
    input logic       o_ack_sampled,
    input logic       o_last
);

    `I2CS_ASSERT_ALWAYS(a_empty_after_reset, i_clk, !i_rst_n |=> empty, "results after reset")

    `I2CS_ASSERT(a_stall_hold, i_clk, i_rst_n, (!empty && !pop) |=> (!empty && $stable(o_scl_level) && $stable(o_sda_level) && $stable(o_last)), "stalled result changed")

    `I2CS_ASSERT(a_mid_fields_zero, i_clk, i_rst_n, (!empty && !o_last) |-> (o_read_data == 8'd0 && !o_ack_sampled), "status on non-last segment")

endmodule

bind i2c_master_byte_sequencer_core i2cs_checker u_i2cs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .empty         (empty),
    .pop           (pop),
    .o_scl_level   (o_scl_level),
    .o_sda_level   (o_sda_level),
    .o_read_data   (o_read_data),
    .o_ack_sampled (o_ack_sampled),
    .o_last        (o_last)
);
